// File: hdl/segi_pkg.sv
`default_nettype none

package segi_pkg;

   // coordinate format and derived arithmetic widths
   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;        // coordinate differences
   localparam int PROD_W  = 2 * DIFF_W;         // difference products
   localparam int SUM_W   = PROD_W + 1;         // det, S and T numerators
   localparam int PT_W    = SUM_W + DIFF_W;     // T times a direction of A
   localparam int QUO_W   = COORD_W + 2;        // quotient bits kept
   localparam int NUM_W   = PT_W + 2;           // 2|P| + det
   localparam int DEN_W   = SUM_W + 1;          // 2 det
   localparam int GEO_LAT = 5;
   localparam int DIV_LAT = QUO_W + 2;

   typedef struct packed {
      logic signed [COORD_W-1:0] a0_x;
      logic signed [COORD_W-1:0] a0_y;
      logic signed [COORD_W-1:0] a1_x;
      logic signed [COORD_W-1:0] a1_y;
      logic signed [COORD_W-1:0] b0_x;
      logic signed [COORD_W-1:0] b0_y;
      logic signed [COORD_W-1:0] b1_x;
      logic signed [COORD_W-1:0] b1_y;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic                      parallel;
      logic signed [COORD_W-1:0] cross_x;
      logic signed [COORD_W-1:0] cross_y;
   } rsp_type;

   typedef struct packed {
      logic                      valid;
      logic                      hit;
      logic                      parallel;
      logic signed [COORD_W-1:0] a0_x;
      logic signed [COORD_W-1:0] a0_y;
      logic signed [PT_W-1:0]    px;
      logic signed [PT_W-1:0]    py;
      logic        [SUM_W-1:0]   det;
   } geo_type;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic             ovf;
      logic [QUO_W-1:0] q;
   } quo_type;

endpackage

`default_nettype wire

// File: hdl/segment_intersection.sv
`default_nettype none

// Segment crossing test for 2-D signed fixed-point segments.
// Request channel: drive req_item with segments A and B and raise start;
// the request is taken at the rising edge where start is high and busy is
// low. busy stays low, so a new request can be taken every cycle.
// Result channel: rsp_strobe is high for one cycle with rsp_item holding
// hit, parallel and the crossing point on the line of A, saturated to the
// coordinate range. Parallel segments give a zero point.
// The pipeline runs five stages of differences, products, sums, sign
// normalization and point products, then a restoring divider with one
// quotient bit per stage plus two setup stages, then one stage of
// rounding sign, offset and saturation.
// Throughput is one request per cycle; results leave in request order.
// The receiver has no way to stall; every result is shown exactly once.
// Synchronous reset clears all valid bits, dropping requests in flight.

module segment_intersection
   import segi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int SIDE_W = 2 + 2 * COORD_W;
   localparam int SUMW   = QUO_W + 2;
   localparam int TOT_LAT = GEO_LAT + DIV_LAT + 1;

   geo_type geo;
   quo_type qx, qy;

   logic [SIDE_W-1:0] side_ff [DIV_LAT];

   logic                   strobe_ff;
   rsp_type                rsp_ff;
   logic                   hit_d, par_d;
   logic signed [COORD_W-1:0] a0x_d, a0y_d;
   logic signed [COORD_W-1:0] cx_in, cy_in;

   assign busy = 1'b0;

   segi_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .req      (req_item),
      .geo      (geo)
   );

   segi_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (geo.valid),
      .num      (geo.px),
      .det      (geo.det),
      .quo      (qx)
   );

   segi_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (geo.valid),
      .num      (geo.py),
      .det      (geo.det),
      .quo      (qy)
   );

   // carry flags and start point alongside the dividers
   always_ff @(posedge clock) begin
      side_ff[0] <= {geo.hit, geo.parallel, geo.a0_x, geo.a0_y};
      for (int i = 0; i < DIV_LAT - 1; i++) begin
         side_ff[i+1] <= side_ff[i];
      end
   end

   assign {hit_d, par_d, a0x_d, a0y_d} = side_ff[DIV_LAT-1];

   function automatic logic signed [COORD_W-1:0] place(
      input logic signed [COORD_W-1:0] base,
      input logic                      neg,
      input logic                      ovf,
      input logic [QUO_W-1:0]          q
   );
      logic signed [QUO_W:0]  sq;
      logic signed [SUMW-1:0] sum;
      logic signed [SUMW-1:0] top;
      logic signed [SUMW-1:0] bot;
      sq  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      sum = SUMW'(base) + SUMW'(sq);
      top = SUMW'({1'b0, {(COORD_W-1){1'b1}}});
      bot = -top - SUMW'(1);
      if (ovf) begin
         place = neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else if (sum > top) begin
         place = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (sum < bot) begin
         place = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         place = sum[COORD_W-1:0];
      end
   endfunction

   always_comb begin
      cx_in = place(a0x_d, qx.neg, qx.ovf, qx.q);
      cy_in = place(a0y_d, qy.neg, qy.ovf, qy.q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= qx.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.hit      <= hit_d & ~par_d;
      rsp_ff.parallel <= par_d;
      rsp_ff.cross_x  <= par_d ? '0 : cx_in;
      rsp_ff.cross_y  <= par_d ? '0 : cy_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TOT_LAT rsp_strobe)
      else $error("result missing at fixed latency");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, TOT_LAT))
      else $error("result without request");

   a_axes_agree: assert property (@(posedge clock) disable iff (reset)
      qx.valid == qy.valid)
      else $error("divider lanes out of step");

   a_par_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.parallel) |->
         (!rsp_item.hit && rsp_item.cross_x == '0 && rsp_item.cross_y == '0))
      else $error("parallel result not cleared");
`endif

endmodule

`default_nettype wire

// File: hdl/segi_geom.sv
`default_nettype none

module segi_geom
   import segi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire req_type req,
   output geo_type      geo
);

   // stage 1: differences
   logic v1_ff;
   logic signed [DIFF_W-1:0] s1x_ff, s1y_ff, s2x_ff, s2y_ff, dx_ff, dy_ff;
   logic signed [COORD_W-1:0] a0x1_ff, a0y1_ff;
   // stage 2: products
   logic v2_ff;
   logic signed [PROD_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [DIFF_W-1:0] s1x2_ff, s1y2_ff;
   logic signed [COORD_W-1:0] a0x2_ff, a0y2_ff;
   // stage 3: det, S, T
   logic v3_ff;
   logic signed [SUM_W-1:0] det_ff, sn_ff, tn_ff;
   logic signed [DIFF_W-1:0] s1x3_ff, s1y3_ff;
   logic signed [COORD_W-1:0] a0x3_ff, a0y3_ff;
   // stage 4: sign normalize and interior test
   logic v4_ff, hit4_ff, par4_ff;
   logic signed [SUM_W-1:0] detn_in, snn_in, tnn_in;
   logic        [SUM_W-1:0] det4_ff;
   logic signed [SUM_W-1:0] tn4_ff;
   logic signed [DIFF_W-1:0] s1x4_ff, s1y4_ff;
   logic signed [COORD_W-1:0] a0x4_ff, a0y4_ff;
   logic hit_in;
   // stage 5: point products
   logic v5_ff, hit5_ff, par5_ff;
   logic signed [PT_W-1:0] px_ff, py_ff;
   logic        [SUM_W-1:0] det5_ff;
   logic signed [COORD_W-1:0] a0x5_ff, a0y5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1x_ff  <= DIFF_W'(req.a0_x) - DIFF_W'(req.a1_x);
      s1y_ff  <= DIFF_W'(req.a0_y) - DIFF_W'(req.a1_y);
      s2x_ff  <= DIFF_W'(req.b0_x) - DIFF_W'(req.b1_x);
      s2y_ff  <= DIFF_W'(req.b0_y) - DIFF_W'(req.b1_y);
      dx_ff   <= DIFF_W'(req.a0_x) - DIFF_W'(req.b0_x);
      dy_ff   <= DIFF_W'(req.a0_y) - DIFF_W'(req.b0_y);
      a0x1_ff <= req.a0_x;
      a0y1_ff <= req.a0_y;

      p1_ff   <= s1x_ff * s2y_ff;
      p2_ff   <= s2x_ff * s1y_ff;
      p3_ff   <= s1x_ff * dy_ff;
      p4_ff   <= s1y_ff * dx_ff;
      p5_ff   <= s2x_ff * dy_ff;
      p6_ff   <= s2y_ff * dx_ff;
      s1x2_ff <= s1x_ff;
      s1y2_ff <= s1y_ff;
      a0x2_ff <= a0x1_ff;
      a0y2_ff <= a0y1_ff;

      det_ff  <= SUM_W'(p1_ff) - SUM_W'(p2_ff);
      sn_ff   <= SUM_W'(p3_ff) - SUM_W'(p4_ff);
      tn_ff   <= SUM_W'(p5_ff) - SUM_W'(p6_ff);
      s1x3_ff <= s1x2_ff;
      s1y3_ff <= s1y2_ff;
      a0x3_ff <= a0x2_ff;
      a0y3_ff <= a0y2_ff;

      det4_ff <= $unsigned(detn_in);
      tn4_ff  <= tnn_in;
      hit4_ff <= hit_in;
      par4_ff <= (det_ff == '0);
      s1x4_ff <= s1x3_ff;
      s1y4_ff <= s1y3_ff;
      a0x4_ff <= a0x3_ff;
      a0y4_ff <= a0y3_ff;

      px_ff   <= tn4_ff * s1x4_ff;
      py_ff   <= tn4_ff * s1y4_ff;
      det5_ff <= det4_ff;
      hit5_ff <= hit4_ff;
      par5_ff <= par4_ff;
      a0x5_ff <= a0x4_ff;
      a0y5_ff <= a0y4_ff;
   end

   // flip all three when det is negative so the interval test sees det > 0
   always_comb begin
      detn_in = det_ff[SUM_W-1] ? -det_ff : det_ff;
      snn_in  = det_ff[SUM_W-1] ? -sn_ff  : sn_ff;
      tnn_in  = det_ff[SUM_W-1] ? -tn_ff  : tn_ff;
      hit_in  = (det_ff != '0) && (snn_in > -detn_in) && snn_in[SUM_W-1]
                && (tnn_in > -detn_in) && tnn_in[SUM_W-1];
   end

   assign geo.valid    = v5_ff;
   assign geo.hit      = hit5_ff;
   assign geo.parallel = par5_ff;
   assign geo.a0_x     = a0x5_ff;
   assign geo.a0_y     = a0y5_ff;
   assign geo.px       = px_ff;
   assign geo.py       = py_ff;
   assign geo.det      = det5_ff;

endmodule

`default_nettype wire

// File: hdl/segi_div.sv
`default_nettype none

module segi_div
   import segi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic signed [PT_W-1:0] num,
   input  wire logic        [SUM_W-1:0] det,
   output quo_type                     quo
);

   // prep stage: rounding numerator 2|P| + det over denominator 2 det
   logic             va_ff, nega_ff;
   logic [NUM_W-1:0] n2_ff;
   logic [DEN_W-1:0] d2a_ff;
   logic [PT_W-1:0]  mag;

   // restoring steps, one quotient bit per stage
   logic             v_ff    [QUO_W+1];
   logic             neg_ff  [QUO_W+1];
   logic             ovf_ff  [QUO_W+1];
   logic [DEN_W-1:0] rem_ff  [QUO_W+1];
   logic [QUO_W-1:0] low_ff  [QUO_W+1];
   logic [QUO_W-1:0] q_ff    [QUO_W+1];
   logic [DEN_W-1:0] d2_ff   [QUO_W+1];

   assign mag = num[PT_W-1] ? $unsigned(-num) : $unsigned(num);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      nega_ff <= num[PT_W-1];
      n2_ff   <= {(NUM_W-1)'(mag), 1'b0} + NUM_W'(det);
      d2a_ff  <= {det, 1'b0};
   end

   // overflow stage: quotient would need more than QUO_W bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff[0] <= nega_ff;
      ovf_ff[0] <= (n2_ff >= {d2a_ff, {QUO_W{1'b0}}});
      rem_ff[0] <= n2_ff[NUM_W-1:QUO_W];
      low_ff[0] <= n2_ff[QUO_W-1:0];
      q_ff[0]   <= '0;
      d2_ff[0]  <= d2a_ff;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           take;

      assign trial = {rem_ff[k], low_ff[k][QUO_W-1]};
      assign take  = (trial >= {1'b0, d2_ff[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= take ? DEN_W'(trial - {1'b0, d2_ff[k]}) : DEN_W'(trial);
         low_ff[k+1] <= {low_ff[k][QUO_W-2:0], 1'b0};
         q_ff[k+1]   <= {q_ff[k][QUO_W-2:0], take};
         neg_ff[k+1] <= neg_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
         d2_ff[k+1]  <= d2_ff[k];
      end
   end

   assign quo.valid = v_ff[QUO_W];
   assign quo.neg   = neg_ff[QUO_W];
   assign quo.ovf   = ovf_ff[QUO_W];
   assign quo.q     = q_ff[QUO_W];

endmodule

`default_nettype wire

// File: dv/segment_intersection_test.sv
`timescale 1ns / 1ps

module segment_intersection_test;
   import segi_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_REQUESTS = 500;

   class crossing_scoreboard;
      rsp_type pending[$];
      int errors = 0;

      function longint round_div(longint p, longint d);
         longint np, nd, q;
         np = (p < 0) ? -p : p;
         nd = (d < 0) ? -d : d;
         q = (2 * np + nd) / (2 * nd);
         return ((p < 0) != (d < 0)) ? -q : q;
      endfunction

      function logic signed [COORD_W-1:0] clamp(longint v);
         if (v < -32768) return 16'sh8000;
         if (v > 32767) return 16'sh7fff;
         return v[COORD_W-1:0];
      endfunction

      function void note_request(req_type r);
         longint s1x, s1y, s2x, s2y, dx, dy, det, sn, tn;
         rsp_type e;
         s1x = longint'(r.a0_x) - longint'(r.a1_x);
         s1y = longint'(r.a0_y) - longint'(r.a1_y);
         s2x = longint'(r.b0_x) - longint'(r.b1_x);
         s2y = longint'(r.b0_y) - longint'(r.b1_y);
         dx = longint'(r.a0_x) - longint'(r.b0_x);
         dy = longint'(r.a0_y) - longint'(r.b0_y);
         det = s1x * s2y - s2x * s1y;
         sn = s1x * dy - s1y * dx;
         tn = s2x * dy - s2y * dx;
         e = '0;
         if (det == 0) begin
            e.parallel = 1'b1;
         end else begin
            if (det < 0) begin
               det = -det;
               sn = -sn;
               tn = -tn;
            end
            e.hit = (sn > -det) && (sn < 0) && (tn > -det) && (tn < 0);
            e.cross_x = clamp(longint'(r.a0_x) + round_div(tn * s1x, det));
            e.cross_y = clamp(longint'(r.a0_y) + round_div(tn * s1y, det));
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with no request pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.hit !== e.hit) begin
            $error("hit: expected %0d, actual %0d", e.hit, got.hit);
            errors++;
         end
         if (got.parallel !== e.parallel) begin
            $error("parallel: expected %0d, actual %0d", e.parallel, got.parallel);
            errors++;
         end
         if (got.cross_x !== e.cross_x) begin
            $error("cross_x: expected %0d, actual %0d", e.cross_x, got.cross_x);
            errors++;
         end
         if (got.cross_y !== e.cross_y) begin
            $error("cross_y: expected %0d, actual %0d", e.cross_y, got.cross_y);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_item;
   logic rsp_strobe;
   rsp_type rsp_item;

   crossing_scoreboard board = new();
   int idle_cycles = 0;

   segment_intersection i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_request(req_item);
         if (rsp_strobe) board.check_result(rsp_item);
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // hold the request until the edge that takes it
   task automatic send_request(input req_type r);
      @(negedge clock);
      start <= 1'b1;
      req_item <= r;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   function automatic req_type make_pair(int ax0, int ay0, int ax1, int ay1,
                                         int bx0, int by0, int bx1, int by1);
      req_type r;
      r.a0_x = COORD_W'(ax0); r.a0_y = COORD_W'(ay0);
      r.a1_x = COORD_W'(ax1); r.a1_y = COORD_W'(ay1);
      r.b0_x = COORD_W'(bx0); r.b0_y = COORD_W'(by0);
      r.b1_x = COORD_W'(bx1); r.b1_y = COORD_W'(by1);
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord(int span);
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1, 2: return COORD_W'($urandom());
         default: return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   function automatic req_type random_pair();
      req_type r;
      int span;
      span = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(4, 2000);
      r = {random_coord(span), random_coord(span), random_coord(span),
           random_coord(span), random_coord(span), random_coord(span),
           random_coord(span), random_coord(span)};
      // echo endpoints now and then so touching and collinear cases recur
      case ($urandom_range(0, 7))
         0: begin r.b0_x = r.a0_x; r.b0_y = r.a0_y; end
         1: begin r.b1_x = r.a1_x; r.b1_y = r.a1_y; end
         2: begin r.b0_x = r.a0_x; r.b0_y = r.a1_y; r.b1_x = r.a1_x; r.b1_y = r.a0_y; end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      req_type directed[$];
      int burst;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(-16, -16, 16, 16, -16, 16, 16, -16));
      directed.push_back(make_pair(0, 0, 160, 0, 0, 16, 160, 16));
      directed.push_back(make_pair(0, 0, 160, 0, 32, 0, 320, 0));
      directed.push_back(make_pair(0, 0, 160, 160, 0, 0, 160, -160));
      directed.push_back(make_pair(0, 0, 160, 160, 160, 160, 320, 0));
      directed.push_back(make_pair(0, 0, 160, 0, 80, 0, 80, 160));
      directed.push_back(make_pair(0, 0, 16, 0, 32, -16, 32, 16));
      directed.push_back(make_pair(-32768, -32768, 32767, 32767,
                                   -32768, 32767, 32767, -32768));
      directed.push_back(make_pair(32767, 32767, -32768, -32768,
                                   32767, -32768, -32768, 32767));
      directed.push_back(make_pair(0, 0, 1, 0, 32767, -32768, 32767, 32767));
      directed.push_back(make_pair(0, 0, -1, 0, -32768, -32768, -32768, 32767));
      directed.push_back(make_pair(0, 0, 0, 1, -32768, 32767, 32767, 32767));
      directed.push_back(make_pair(32767, 0, 32766, 1, -32768, 0, -32768, 1));
      directed.push_back(make_pair(0, 0, 3, 0, 1, -1, 2, 1));
      directed.push_back(make_pair(0, 0, 3, 1, 1, -5, 2, 7));
      directed.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
      directed.push_back(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
      directed.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
      directed.push_back(make_pair(32767, 32767, 32767, 32767,
                                   -32768, -32768, -32768, -32768));
      foreach (directed[i]) send_request(directed[i]);

      hold_off(1);
      while (board.pending.size() != 0) @(negedge clock);

      for (int n = 0; n < RANDOM_REQUESTS; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < RANDOM_REQUESTS; k++, n++) begin
            send_request(random_pair());
         end
         hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30));
      end
      hold_off(1);

      while (board.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// File: sim.f
hdl/segi_pkg.sv
hdl/segi_geom.sv
hdl/segi_div.sv
hdl/segment_intersection.sv
dv/segment_intersection_test.sv
